// ----- rtl/core/pha_pkg.sv -----
`default_nettype none

package pha_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF    = 18;

    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 15;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;
    localparam int ACC_FRAC   = 16;
    localparam int Z_W        = 26;
    localparam int ATAN_IDX_W = 5;
    localparam int DP_W       = 60;
    localparam int SCALE_BASE = 56;

    localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;
    localparam logic signed [Z_W-1:0] Z_FULL    = 26'sd23592960;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROTATE,
        ST_ANGLE,
        ST_WRAP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic rotate;
        logic angle;
        logic wrap;
        logic result;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic coincident;
        logic last_step;
        logic out_free;
    } status_t;

    // atan(2^-i) in degrees, 16 fraction bits, rounded
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        unique case (idx)
            5'd0:    r = 26'sd2949120;
            5'd1:    r = 26'sd1740967;
            5'd2:    r = 26'sd919879;
            5'd3:    r = 26'sd466945;
            5'd4:    r = 26'sd234379;
            5'd5:    r = 26'sd117304;
            5'd6:    r = 26'sd58666;
            5'd7:    r = 26'sd29335;
            5'd8:    r = 26'sd14668;
            5'd9:    r = 26'sd7334;
            5'd10:   r = 26'sd3667;
            5'd11:   r = 26'sd1833;
            5'd12:   r = 26'sd917;
            5'd13:   r = 26'sd458;
            5'd14:   r = 26'sd229;
            5'd15:   r = 26'sd115;
            5'd16:   r = 26'sd57;
            5'd17:   r = 26'sd29;
            5'd18:   r = 26'sd14;
            5'd19:   r = 26'sd7;
            5'd20:   r = 26'sd4;
            5'd21:   r = 26'sd2;
            5'd22:   r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pha_ctrl.sv -----
`default_nettype none

module pha_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire pha_pkg::status_t  status,
    output logic                   s_tready,
    output pha_pkg::cmd_t          cmd
);

    pha_pkg::state_t state_reg;
    pha_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pha_pkg::ST_IDLE:
            begin
                if (s_tvalid && !status.start)
                begin
                    state_next = pha_pkg::ST_SETUP;
                end
            end
            pha_pkg::ST_SETUP:
            begin
                state_next = status.coincident ? pha_pkg::ST_RESULT : pha_pkg::ST_ROTATE;
            end
            pha_pkg::ST_ROTATE:
            begin
                if (status.last_step)
                begin
                    state_next = pha_pkg::ST_ANGLE;
                end
            end
            pha_pkg::ST_ANGLE:
            begin
                state_next = pha_pkg::ST_WRAP;
            end
            pha_pkg::ST_WRAP:
            begin
                state_next = pha_pkg::ST_RESULT;
            end
            pha_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = pha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == pha_pkg::ST_IDLE);
        cmd        = '0;
        cmd.load   = (state_reg == pha_pkg::ST_IDLE) && s_tvalid;
        cmd.setup  = (state_reg == pha_pkg::ST_SETUP);
        cmd.rotate = (state_reg == pha_pkg::ST_ROTATE);
        cmd.angle  = (state_reg == pha_pkg::ST_ANGLE);
        cmd.wrap   = (state_reg == pha_pkg::ST_WRAP);
        cmd.result = (state_reg == pha_pkg::ST_RESULT) && status.out_free;
    end

endmodule

`default_nettype wire

// ----- rtl/core/pha_datapath.sv -----
`default_nettype none

module pha_datapath #(
    parameter int COORD_WIDTH     = pha_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = pha_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = pha_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pha_pkg::cmd_t                 cmd,
    output pha_pkg::status_t                   status,
    input  wire logic [pha_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pha_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int CW        = COORD_WIDTH;
    localparam int FW        = pha_pkg::FIELD_W;
    localparam int OW        = pha_pkg::OUT_W;
    localparam int MW        = pha_pkg::M_DATA_W;
    localparam int DW        = pha_pkg::DP_W;
    localparam int ZW        = pha_pkg::Z_W;
    localparam int IDX_W     = pha_pkg::ATAN_IDX_W;
    localparam int SCALE     = pha_pkg::SCALE_BASE - COORD_WIDTH;
    localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int HW        = $clog2(FULL_TURN);
    localparam int RS        = pha_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int HALF      = 2 ** (RS - 1);
    localparam int STEP_W    = $clog2(CORDIC_STEPS);

    logic [FW-1:0]          x_field;
    logic [FW-1:0]          y_field;
    logic [CW-1:0]          x_c;
    logic [CW-1:0]          y_c;
    logic signed [CW:0]     dx_in;
    logic signed [CW:0]     dy_in;

    logic [CW-1:0]          prev_x_reg;
    logic [CW-1:0]          prev_y_reg;
    logic                   open_reg;
    logic [HW-1:0]          heading_reg;
    logic                   m_tvalid_reg;
    logic [MW-1:0]          m_tdata_reg;
    logic [MW-1:0]          m_tdata_next;

    logic signed [CW:0]     dx_reg;
    logic signed [CW:0]     dy_reg;
    logic                   coin_reg;
    logic signed [DW-1:0]   vx_reg;
    logic signed [DW-1:0]   vy_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [HW-1:0]          bear_reg;

    logic signed [DW-1:0]   sdx;
    logic signed [DW-1:0]   sdy;
    logic signed [DW-1:0]   sx;
    logic signed [DW-1:0]   sy;
    logic                   rot_up;
    logic signed [ZW-1:0]   atan_i;
    logic signed [ZW-1:0]   zp;
    logic [ZW-1:0]          z_round;
    logic [HW-1:0]          bear_angle;
    logic [HW-1:0]          bear_wrap;
    logic [HW:0]            turn_w;
    logic [31:0]            turn32;
    logic [31:0]            nh32;

    assign x_field = s_tdata[FW-1:0];
    assign y_field = s_tdata[2*FW-1:FW];

    generate
        if (CW <= FW)
        begin : g_narrow
            assign x_c = x_field[CW-1:0];
            assign y_c = y_field[CW-1:0];
        end
        else
        begin : g_wide
            assign x_c = {{(CW-FW){1'b0}}, x_field};
            assign y_c = {{(CW-FW){1'b0}}, y_field};
        end
    endgenerate

    assign dx_in = {x_c[CW-1], x_c} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy_in = {y_c[CW-1], y_c} - {prev_y_reg[CW-1], prev_y_reg};

    assign sdx = {{(DW-CW-1){dx_reg[CW]}}, dx_reg} << SCALE;
    assign sdy = {{(DW-CW-1){dy_reg[CW]}}, dy_reg} << SCALE;

    assign sx     = vx_reg >>> step_reg;
    assign sy     = vy_reg >>> step_reg;
    assign rot_up = !vy_reg[DW-1];
    assign atan_i = pha_pkg::atan_q16(IDX_W'(step_reg));

    assign zp         = z_reg[ZW-1] ? z_reg + pha_pkg::Z_FULL : z_reg;
    assign z_round    = zp + ZW'(HALF);
    assign bear_angle = HW'(z_round >> RS);
    assign bear_wrap  = (bear_reg >= HW'(FULL_TURN)) ? bear_reg - HW'(FULL_TURN) : bear_reg;

    assign turn_w = (bear_reg >= heading_reg)
                  ? {1'b0, bear_reg} - {1'b0, heading_reg}
                  : {1'b0, bear_reg} + (HW+1)'(FULL_TURN) - {1'b0, heading_reg};
    assign turn32 = 32'(turn_w[HW-1:0]);
    assign nh32   = 32'(bear_reg);
    assign m_tdata_next = {{(MW-2*OW){1'b0}}, nh32[OW-1:0], turn32[OW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            open_reg     <= 1'b0;
            heading_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_x_reg <= x_c;
                prev_y_reg <= y_c;
                if (status.start)
                begin
                    heading_reg <= '0;
                    open_reg    <= 1'b1;
                end
            end
            if (cmd.result)
            begin
                heading_reg  <= bear_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= dx_in;
            dy_reg   <= dy_in;
            coin_reg <= (dx_in == '0) && (dy_in == '0);
        end
        if (cmd.result)
        begin
            m_tdata_reg <= m_tdata_next;
        end
        priority if (cmd.setup)
        begin
            step_reg <= '0;
            bear_reg <= heading_reg;
            if (dy_reg[CW])
            begin
                if (!dx_reg[CW])
                begin
                    vx_reg <= sdx;
                    vy_reg <= -sdy;
                    z_reg  <= pha_pkg::Z_QUARTER;
                end
                else
                begin
                    vx_reg <= -sdx;
                    vy_reg <= sdy;
                    z_reg  <= -pha_pkg::Z_QUARTER;
                end
            end
            else
            begin
                vx_reg <= sdy;
                vy_reg <= sdx;
                z_reg  <= '0;
            end
        end
        else if (cmd.rotate)
        begin
            step_reg <= STEP_W'(step_reg + 1'b1);
            if (rot_up)
            begin
                vx_reg <= vx_reg + sy;
                vy_reg <= vy_reg - sx;
                z_reg  <= z_reg + atan_i;
            end
            else
            begin
                vx_reg <= vx_reg - sy;
                vy_reg <= vy_reg + sx;
                z_reg  <= z_reg - atan_i;
            end
        end
        else if (cmd.angle)
        begin
            bear_reg <= bear_angle;
        end
        else if (cmd.wrap)
        begin
            bear_reg <= bear_wrap;
        end
        else
        begin
        end
    end

    always_comb
    begin
        status            = '0;
        status.start      = s_tuser || !open_reg;
        status.coincident = coin_reg;
        status.last_step  = (step_reg == STEP_W'(CORDIC_STEPS - 1));
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/path_heading_adjust.sv -----
`default_nettype none

// Path heading adjust. Each beat in carries a point; a start beat (tuser high, or any beat
// before the first start) records the point, zeroes the heading and gives no result. Every
// later point gives one result beat: the clockwise turn from the current heading to the
// bearing of the new point, and the new absolute heading, both in 1/2^ANGLE_FRAC_BITS degree
// and wrapped to [0, 360). Coincident points give turn 0 and keep the heading. One point is
// in work at a time: a start point is only recorded, a coincident point goes from setup straight
// to result, and any other point passes setup, the CORDIC vectoring pass, angle, wrap and result;
// the pass iterates through the single micro-rotation unit, one step per cycle. A finished
// result sits in the output register, so the next point is taken while it waits.
module path_heading_adjust #(
    parameter int COORD_WIDTH     = pha_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = pha_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = pha_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pha_pkg::S_DATA_W-1:0]  s_tdata,   // x_coord[15:0], y_coord[31:16]
    input  wire logic                          s_tuser,   // kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pha_pkg::M_DATA_W-1:0]       m_tdata    // turn_angle[14:0], new_heading[29:15]
);

    localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int OW        = pha_pkg::OUT_W;

    pha_pkg::cmd_t    cmd;
    pha_pkg::status_t status;

    pha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    pha_datapath #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.setup, cmd.rotate, cmd.angle, cmd.wrap, cmd.result}))
        else $error("more than one datapath command active");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> m_tvalid)
        else $error("result not presented after load");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (FULL_TURN > (2 ** OW - 1)) || (32'(m_tdata[OW-1:0]) < FULL_TURN))
        else $error("turn angle out of range");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (FULL_TURN > (2 ** OW - 1)) || (32'(m_tdata[2*OW-1:OW]) < FULL_TURN))
        else $error("heading out of range");

endmodule

`default_nettype wire

// ----- sim/path_heading_adjust_test.sv -----
`timescale 1ns / 100ps

module path_heading_adjust_test;

    import pha_pkg::*;

    localparam int ANG_FRAC    = ANGLE_FRAC_BITS_DEF;
    localparam int FULL_TURN   = 360 << ANG_FRAC;
    localparam int ROUND_SHIFT = ACC_FRAC - ANG_FRAC;
    localparam int PRE_SHIFT   = SCALE_BASE - COORD_WIDTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_POINTS = 1330;
    localparam int BLOCK_LEN   = 150;

    // atan(2^-i), degrees with 16 fraction bits
    localparam longint MICRO_ATAN [23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               typed;
        logic               has_res;
        logic [OUT_W-1:0]   turn;
        logic [OUT_W-1:0]   head;
    } point_row_t;

    typedef struct {
        logic [OUT_W-1:0] turn;
        logic [OUT_W-1:0] head;
    } turn_res_t;

    // typed rows: axis and diagonal bearings, coincident points, start handling
    localparam int N_ROWS = 24;
    localparam point_row_t POINT_ROWS [N_ROWS] = '{
        '{1'b0,      16'sd0,      16'sd0, 1'b1, 1'b0,     15'd0,     15'd0},
        '{1'b0,      16'sd0,    16'sd100, 1'b1, 1'b1,     15'd0,     15'd0},
        '{1'b0,      16'sd0,    16'sd100, 1'b1, 1'b1,     15'd0,     15'd0},
        '{1'b0,    16'sd100,    16'sd100, 1'b1, 1'b1,  15'd5760,  15'd5760},
        '{1'b0,    16'sd100,   -16'sd32768, 1'b1, 1'b1,  15'd5760, 15'd11520},
        '{1'b0, -16'sd32768,  -16'sd32768, 1'b1, 1'b1,  15'd5760, 15'd17280},
        '{1'b0, -16'sd32768,  -16'sd32768, 1'b1, 1'b1,     15'd0, 15'd17280},
        '{1'b0,  16'sd32767,   16'sd32767, 1'b1, 1'b1,  15'd8640,  15'd2880},
        '{1'b1,  16'sd32767,  -16'sd32768, 1'b1, 1'b0,     15'd0,     15'd0},
        '{1'b0, -16'sd32768,   16'sd32767, 1'b1, 1'b1, 15'd20160, 15'd20160},
        '{1'b0, -16'sd32768,   16'sd32767, 1'b1, 1'b1,     15'd0, 15'd20160},
        '{1'b1,      16'sd5,      16'sd5, 1'b1, 1'b0,     15'd0,     15'd0},
        '{1'b0,      16'sd5,      16'sd5, 1'b1, 1'b1,     15'd0,     15'd0},
        '{1'b0,     -16'sd1,     -16'sd1, 1'b1, 1'b1, 15'd14400, 15'd14400},
        '{1'b0,      16'sd0,      16'sd0, 1'b1, 1'b1, 15'd11520,  15'd2880},
        '{1'b0,      16'sd1,      16'sd2, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0,      16'sd4,     -16'sd5, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0, -16'sd32768,      16'sd0, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b1,     -16'sd7,      16'sd3, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b1,    16'sd100,    -16'sd100, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0,  16'sd32767,  -16'sd32768, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0, -16'sd21846,   16'sd21845, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0, -16'sd21845,   16'sd21845, 1'b0, 1'b0,     15'd0,     15'd0},
        '{1'b0,  16'sd12345,   -16'sd4321, 1'b0, 1'b0,     15'd0,     15'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // x_coord[15:0], y_coord[31:16]
    logic                s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // turn_angle[14:0], new_heading[29:15]

    turn_res_t        pending_turns [$];
    turn_res_t        want;
    int               n_err;
    int               n_points;
    int               n_starts;
    int               n_coinc;
    int               n_beats;
    int               idle_cycles;
    bit               calm;

    int               trail_x;
    int               trail_y;
    logic [OUT_W-1:0] trail_heading;
    bit               trail_open;

    path_heading_adjust u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // clockwise bearing from +Y, CORDIC vectoring on (dy, dx)
    function automatic logic [OUT_W-1:0] compass_bearing(input longint dx, input longint dy);
        longint vx;
        longint vy;
        longint z;
        longint t;
        longint sx;
        longint sy;
        longint b;
        vx = dy <<< PRE_SHIFT;
        vy = dx <<< PRE_SHIFT;
        z  = 0;
        if (vx < 0)
        begin
            if (vy >= 0)
            begin
                t  = vx;
                vx = vy;
                vy = -t;
                z  = longint'(90) <<< ACC_FRAC;
            end
            else
            begin
                t  = vx;
                vx = -vy;
                vy = t;
                z  = -(longint'(90) <<< ACC_FRAC);
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0)
            begin
                vx = vx + sy;
                vy = vy - sx;
                z  = z + ((i < 23) ? MICRO_ATAN[i] : 0);
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
                z  = z - ((i < 23) ? MICRO_ATAN[i] : 0);
            end
        end
        if (z < 0)
            z = z + (longint'(360) <<< ACC_FRAC);
        b = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        while (b >= FULL_TURN)
            b = b - FULL_TURN;
        return b[OUT_W-1:0];
    endfunction

    task automatic advance_path(input bit kind, input int px, input int py,
                                output bit has_res, output turn_res_t res);
        int dx;
        int dy;
        int h;
        int nh;
        dx = px - trail_x;
        dy = py - trail_y;
        has_res = 1'b0;
        res     = '{default: '0};
        if (kind || !trail_open)
        begin
            trail_heading = '0;
            trail_open    = 1'b1;
            n_starts++;
        end
        else
        begin
            h = int'(trail_heading) % FULL_TURN;
            if (dx == 0 && dy == 0)
            begin
                nh = h;
                res.turn = '0;
                n_coinc++;
            end
            else
            begin
                nh = compass_bearing(dx, dy);
                res.turn = OUT_W'((nh + FULL_TURN - h) % FULL_TURN);
            end
            res.head      = OUT_W'(nh);
            trail_heading = OUT_W'(nh);
            has_res       = 1'b1;
        end
        trail_x = px;
        trail_y = py;
    endtask

    task automatic send_point(input bit kind, input int px, input int py, input bit typed,
                              input bit typed_res, input turn_res_t typed_val);
        int        gap;
        bit        has_res;
        turn_res_t res;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(py), 16'(px)};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        n_points++;
        advance_path(kind, int'(shortint'(px)), int'(shortint'(py)), has_res, res);
        if (typed)
        begin
            has_res = typed_res;
            res     = typed_val;
        end
        if (has_res)
            pending_turns.insert(pending_turns.size(), res);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_turns.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_beats++;
            if (pending_turns.size() == 0)
            begin
                $error("result beat with no point pending: %h", m_tdata);
                n_err++;
            end
            else
            begin
                want = pending_turns.pop_front();
                if (m_tdata[14:0] !== want.turn)
                begin
                    $error("turn_angle: expected %0d, got %0d", want.turn, m_tdata[14:0]);
                    n_err++;
                end
                if (m_tdata[29:15] !== want.head)
                begin
                    $error("new_heading: expected %0d, got %0d", want.head, m_tdata[29:15]);
                    n_err++;
                end
                if (m_tdata[M_DATA_W-1:30] !== '0)
                begin
                    $error("pad: expected 0, got %0d", m_tdata[M_DATA_W-1:30]);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int        r;
        int        nx;
        int        ny;
        int        cur_x;
        int        cur_y;
        bit        kind;
        turn_res_t typed_val;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        calm          = 1'b0;
        n_err         = 0;
        n_points      = 0;
        n_starts      = 0;
        n_coinc       = 0;
        n_beats       = 0;
        idle_cycles   = 0;
        trail_x       = 0;
        trail_y       = 0;
        trail_heading = '0;
        trail_open    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            typed_val.turn = POINT_ROWS[i].turn;
            typed_val.head = POINT_ROWS[i].head;
            send_point(POINT_ROWS[i].kind, POINT_ROWS[i].x, POINT_ROWS[i].y,
                       POINT_ROWS[i].typed, POINT_ROWS[i].has_res, typed_val);
        end
        cur_x = POINT_ROWS[N_ROWS-1].x;
        cur_y = POINT_ROWS[N_ROWS-1].y;

        typed_val = '{default: '0};
        for (int n = 0; n < RAND_POINTS; n++)
        begin
            if (n % BLOCK_LEN == 0)
            begin
                wait_drained();
                calm = ((n / BLOCK_LEN) % 3 == 2);
            end
            r    = $urandom_range(0, 99);
            kind = 1'b0;
            if (r < 6)
            begin
                kind = 1'b1;
                nx   = shortint'($urandom);
                ny   = shortint'($urandom);
            end
            else if (r < 10)
            begin
                nx = cur_x;
                ny = cur_y;
            end
            else if (r < 45)
            begin
                nx = cur_x + $urandom_range(0, 32) - 16;
                ny = cur_y + $urandom_range(0, 32) - 16;
            end
            else if (r < 75)
            begin
                nx = cur_x + $urandom_range(0, 4000) - 2000;
                ny = cur_y + $urandom_range(0, 4000) - 2000;
            end
            else
            begin
                nx = shortint'($urandom);
                ny = shortint'($urandom);
            end
            if (nx < -32768 || nx > 32767 || ny < -32768 || ny > 32767)
            begin
                nx = shortint'($urandom);
                ny = shortint'($urandom);
            end
            send_point(kind, nx, ny, 1'b0, 1'b0, typed_val);
            cur_x = nx;
            cur_y = ny;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Walked %0d path points (%0d path starts, %0d coincident), checked %0d results.",
                 n_points, n_starts, n_coinc, n_beats);
        $display("Bearings hit all axes, diagonals and full-range coordinate jumps.");
        if (n_err == 0 && pending_turns.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
